// ===== rtl/rcg_pkg.sv =====
// rcg_pkg: shared types, constants and sizes for the capture group span scanner
// depends on nothing; imported by the top, rcg_scan_core and rcg_out_queue
`default_nettype none

package rcg_pkg;

   // sizes
   localparam int STACK_DEPTH     = 16;
   localparam int MAX_PATTERN_LEN = 4096;
   localparam int MAX_GROUPS      = 9;
   localparam int POS_W           = $clog2(MAX_PATTERN_LEN);
   localparam int ADDR_W          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int LVL_W           = 8;
   localparam int CNT_W           = 4;

   // saturation points
   localparam logic [CNT_W-1:0] COUNT_SAT = CNT_W'(10);
   localparam logic [LVL_W-1:0] LEVEL_SAT = LVL_W'(255);

   // code units that the scanner reacts to
   localparam logic [15:0] CH_LPAREN    = 16'h0028;
   localparam logic [15:0] CH_RPAREN    = 16'h0029;
   localparam logic [15:0] CH_LBRACK    = 16'h005B;
   localparam logic [15:0] CH_RBRACK    = 16'h005D;
   localparam logic [15:0] CH_QUESTION  = 16'h003F;
   localparam logic [15:0] CH_BACKSLASH = 16'h005C;

   typedef struct packed {
      logic [15:0] char_code;
      logic        last_char;
   } req_type;

   typedef struct packed {
      logic        span_valid;
      logic [3:0]  group_number;
      logic [11:0] span_start;
      logic [11:0] span_length;
      logic        pattern_done;
      logic [3:0]  capture_total;
      logic        nesting_overflow;
   } rsp_type;

   // one stack entry
   typedef struct packed {
      logic [POS_W-1:0] start;
      logic             capturing;
      logic [CNT_W-1:0] number;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage : rcg_pkg

`default_nettype wire

// ===== rtl/regex_capture_group_span_scanner.sv =====
// an accepted unit's result is registered in the queue before it shows on rsp
// throughput: one code unit per cycle unless the queue is full; stack memory is
//   read ahead, at the current top's address; a write just made is forwarded
// a two-entry result queue lets units keep coming while a result waits
// reset: synchronous, clears scan state and queue; stack contents stay unknown
`default_nettype none

module regex_capture_group_span_scanner (
   input  wire logic             clock,
   input  wire logic             reset,
   // input items
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire rcg_pkg::req_type req_data,
   // result items
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rcg_pkg::rsp_type      rsp_data
);
   import rcg_pkg::*;

   logic    accept;
   logic    push;
   rsp_type push_data;
   logic    full;

   // an item goes in whenever the queue has a free slot
   assign accept    = req_valid && !req_stall;
   assign req_stall = full;

   // scan state, nesting stack in memory, result forming
   rcg_scan_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .push     (push),
      .push_data(push_data)
   );

   // decouples the scan from a stalled result side
   rcg_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .full     (full),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // a full queue always has a result to offer
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("stall without pending result");

   // a reported span carries a group number in range, no report carries none
   a_group_range: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_data.span_valid ? (push_data.group_number >= 4'd1
                && push_data.group_number <= 4'(MAX_GROUPS))
               : (push_data.group_number == 4'd0)))
      else $error("group number out of range");

   // the capture total never passes its saturation point
   a_count_sat: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_data.capture_total <= COUNT_SAT))
      else $error("capture total above saturation");

   // every result is either a span or a pattern end
   a_result_reason: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_data.span_valid || push_data.pattern_done))
      else $error("result without reason");

endmodule : regex_capture_group_span_scanner

`default_nettype wire

// ===== rtl/rcg_ram.sv =====
// rcg_ram: generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module rcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : rcg_ram

`default_nettype wire

// ===== rtl/rcg_scan_core.sv =====
// rcg_scan_core: per-unit scan state, stack memory access and result forming
// depends on rcg_pkg and rcg_ram
`default_nettype none

module rcg_scan_core (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire rcg_pkg::req_type req_data,
   output logic                 push,
   output rcg_pkg::rsp_type     push_data
);
   import rcg_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             in_class_ff, in_class_in;
   logic             skip_ff, skip_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LVL_W-1:0] lvl_ff, lvl_in;
   logic             ovf_ff, ovf_in;
   logic             fwd_ff, fwd_in;
   entry_type        fwd_data_ff;

   logic              we;
   logic [ADDR_W-1:0] waddr;
   logic [ADDR_W-1:0] raddr;
   entry_type         wdata;
   logic [ENTRY_W-1:0] rd_bits;

   logic [LVL_W-1:0] lvl_m1;
   logic [LVL_W-1:0] lvl_in_m1;
   entry_type        pend_entry;
   entry_type        top;
   logic             res_valid;
   logic [POS_W-1:0] sstart;
   logic [POS_W-1:0] slen;
   logic [CNT_W-1:0] grp;

   assign lvl_m1    = lvl_ff - LVL_W'(1);
   assign lvl_in_m1 = lvl_in - LVL_W'(1);
   assign waddr     = lvl_m1[ADDR_W-1:0];
   assign raddr     = lvl_in_m1[ADDR_W-1:0];

   rcg_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (we),
      .wr_addr(waddr),
      .wr_data(wdata),
      .rd_addr(raddr),
      .rd_data(rd_bits)
   );

   always_comb begin
      logic [15:0] c;
      logic        cap;
      c           = req_data.char_code;
      cap         = 1'b0;
      pos_in      = pos_ff;
      in_class_in = in_class_ff;
      skip_in     = skip_ff;
      pend_in     = pend_ff;
      cnt_in      = cnt_ff;
      lvl_in      = lvl_ff;
      ovf_in      = ovf_ff;
      we          = 1'b0;
      res_valid   = 1'b0;
      sstart      = '0;
      slen        = '0;
      grp         = '0;

      // entry of the open just before this unit, decided now
      cap = (c != CH_QUESTION);
      pend_entry.start     = pos_ff - POS_W'(1);
      pend_entry.capturing = cap;
      pend_entry.number    = '0;

      if (accept) begin
         if (pend_ff) begin
            pend_in = 1'b0;
            if (cap) begin
               if (cnt_in < COUNT_SAT) begin
                  cnt_in = cnt_in + CNT_W'(1);
               end
               pend_entry.number = cnt_in;
            end
            // written back only if stored and the pattern goes on
            we = (9'(lvl_m1) < 9'(STACK_DEPTH)) && !req_data.last_char;
         end

         if (skip_ff) begin
            skip_in = 1'b0;
         end else if (in_class_ff) begin
            if (c == CH_RBRACK) begin
               in_class_in = 1'b0;
            end
         end else if (c == CH_BACKSLASH) begin
            skip_in = 1'b1;
         end else if (c == CH_LPAREN) begin
            if (lvl_ff == LEVEL_SAT) begin
               ovf_in = 1'b1;
            end else begin
               if (!(9'(lvl_ff) < 9'(STACK_DEPTH))) begin
                  ovf_in = 1'b1;
               end
               lvl_in = lvl_ff + LVL_W'(1);
               if (req_data.last_char) begin
                  if (cnt_in < COUNT_SAT) begin
                     cnt_in = cnt_in + CNT_W'(1);
                  end
               end else begin
                  pend_in = 1'b1;
               end
            end
         end else if (c == CH_RPAREN) begin
            if (lvl_ff != '0) begin
               lvl_in = lvl_m1;
               if (9'(lvl_m1) < 9'(STACK_DEPTH)) begin
                  if (top.capturing && top.number >= CNT_W'(1)
                      && top.number <= CNT_W'(MAX_GROUPS)) begin
                     res_valid = 1'b1;
                     grp       = top.number;
                     sstart    = top.start + POS_W'(1);
                     slen      = pos_ff - sstart;
                  end
               end
            end
         end else if (c == CH_LBRACK) begin
            in_class_in = 1'b1;
         end

         pos_in = pos_ff + POS_W'(1);

         if (req_data.last_char) begin
            pos_in      = '0;
            in_class_in = 1'b0;
            skip_in     = 1'b0;
            pend_in     = 1'b0;
            lvl_in      = '0;
         end
      end
   end

   // stack top: the open decided in this step, a write just made, or memory
   always_comb begin
      if (pend_ff) begin
         top = pend_entry;
      end else if (fwd_ff) begin
         top = fwd_data_ff;
      end else begin
         top = entry_type'(rd_bits);
      end
   end

   assign wdata  = pend_entry;
   assign fwd_in = we && (waddr == raddr);

   always_comb begin
      push                       = accept && (res_valid || req_data.last_char);
      push_data.span_valid       = res_valid;
      push_data.group_number     = grp;
      push_data.span_start       = 12'(sstart);
      push_data.span_length      = 12'(slen);
      push_data.pattern_done     = req_data.last_char;
      push_data.capture_total    = cnt_in;
      push_data.nesting_overflow = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         in_class_ff <= 1'b0;
         skip_ff     <= 1'b0;
         pend_ff     <= 1'b0;
         cnt_ff      <= '0;
         lvl_ff      <= '0;
         ovf_ff      <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         in_class_ff <= in_class_in;
         skip_ff     <= skip_in;
         pend_ff     <= pend_in;
         cnt_ff      <= (accept && req_data.last_char) ? '0 : cnt_in;
         lvl_ff      <= lvl_in;
         ovf_ff      <= (accept && req_data.last_char) ? 1'b0 : ovf_in;
         fwd_ff      <= fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_data_ff <= wdata;
   end

endmodule : rcg_scan_core

`default_nettype wire

// ===== rtl/rcg_out_queue.sv =====
// rcg_out_queue: two-entry result queue between the scan core and rsp channel
// depends on rcg_pkg
`default_nettype none

module rcg_out_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rcg_pkg::rsp_type push_data,
   output logic                  full,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output rcg_pkg::rsp_type      rsp_data
);
   import rcg_pkg::*;

   rsp_type    slot_ff [2];
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule : rcg_out_queue

`default_nettype wire
